>>> src/cdq_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes, types and pointer helpers for the circular deque ring
package cdq_pkg;

	localparam int DEPTH  = 16;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DATA_W = 32;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;
	localparam int IN_W   = 40;
	localparam int OUT_W  = 40;

	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic exec;
		logic capture_rd;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pop_go;
		logic out_free;
	} dp_stat_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == '0) begin
			r = PTR_W'(DEPTH - 1);
		end else begin
			r = p - PTR_W'(1);
		end
		return r;
	endfunction

endpackage

>>> src/cdq_ram.sv
`timescale 1ns / 1ps
// generic ram, one write port and one registered read port
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/cdq_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the deque: accept, execute, read wait, result load
module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  cdq_pkg::dp_stat_t stat,
	output cdq_pkg::ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_READ   = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.pop_go ? S_READ : S_RESULT;
			end
			S_READ: begin
				cmd.capture_rd = 1'b1;
				state_d        = S_RESULT;
			end
			S_RESULT: begin
				// wait for the output register to be free
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/cdq_dpath.sv
`timescale 1ns / 1ps
// deque datapath: pointers, ring store, result and output registers
module cdq_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [cdq_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cdq_pkg::OUT_W-1:0]    m_tdata,
	input  cdq_pkg::ctl_cmd_t            cmd,
	output cdq_pkg::dp_stat_t            stat
);

	logic [cdq_pkg::CMD_W-1:0]  cmd_q;
	logic [cdq_pkg::DATA_W-1:0] item_q;
	logic [cdq_pkg::PTR_W-1:0]  back_q, front_q;
	logic [cdq_pkg::STAT_W-1:0] res_status_q;
	logic [cdq_pkg::DATA_W-1:0] res_popped_q;
	logic                       out_valid_q;
	logic [cdq_pkg::DATA_W-1:0] out_popped_q;
	logic [cdq_pkg::STAT_W-1:0] out_status_q;
	logic                       out_empty_q, out_full_q;

	logic                       is_push, is_full, is_empty, push_ok, pop_ok;
	logic [cdq_pkg::PTR_W-1:0]  back_inc, front_inc, wr_addr, rd_addr;
	logic [cdq_pkg::STAT_W-1:0] status_d;
	logic [cdq_pkg::DATA_W-1:0] rd_data;

	assign back_inc  = cdq_pkg::ptr_inc(back_q);
	assign front_inc = cdq_pkg::ptr_inc(front_q);
	assign is_push   = (cmd_q == cdq_pkg::CMD_PUSH_BACK) || (cmd_q == cdq_pkg::CMD_PUSH_FRONT);
	assign is_empty  = (back_q == front_q);
	assign is_full   = (back_inc == front_q);
	assign push_ok   = is_push && !is_full;
	assign pop_ok    = !is_push && !is_empty;

	assign wr_addr = (cmd_q == cdq_pkg::CMD_PUSH_BACK) ? back_inc : front_q;
	assign rd_addr = (cmd_q == cdq_pkg::CMD_POP_BACK) ? back_q : front_inc;

	always_comb begin
		if (is_push) begin
			status_d = is_full ? cdq_pkg::ST_FULL : cdq_pkg::ST_DONE;
		end else begin
			status_d = is_empty ? cdq_pkg::ST_EMPTY : cdq_pkg::ST_DONE;
		end
	end

	assign stat.pop_go   = pop_ok;
	assign stat.out_free = !out_valid_q || m_tready;

	cdq_ram #(
		.WIDTH(cdq_pkg::DATA_W),
		.DEPTH(cdq_pkg::DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (cmd.exec && push_ok),
		.waddr(wr_addr),
		.wdata(item_q),
		.re   (cmd.exec && pop_ok),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_q      <= '0;
			front_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (push_ok) begin
					if (cmd_q == cdq_pkg::CMD_PUSH_BACK) begin
						back_q <= back_inc;
					end else begin
						front_q <= cdq_pkg::ptr_dec(front_q);
					end
				end else if (pop_ok) begin
					if (cmd_q == cdq_pkg::CMD_POP_BACK) begin
						back_q <= cdq_pkg::ptr_dec(back_q);
					end else begin
						front_q <= front_inc;
					end
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q  <= s_tdata[cdq_pkg::CMD_W-1:0];
			item_q <= s_tdata[cdq_pkg::CMD_W +: cdq_pkg::DATA_W];
		end
		if (cmd.exec) begin
			res_status_q <= status_d;
			res_popped_q <= '0;
		end else if (cmd.capture_rd) begin
			res_popped_q <= rd_data;
		end
		if (cmd.load_out) begin
			// flags reflect the pointers after the operation
			out_popped_q <= res_popped_q;
			out_status_q <= res_status_q;
			out_empty_q  <= is_empty;
			out_full_q   <= is_full;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_full_q, out_empty_q, out_status_q, out_popped_q};

endmodule

>>> src/circular_deque_ring.sv
`timescale 1ns / 1ps
// Double-ended queue in a ring of cdq_pkg::DEPTH slots holding up to DEPTH-1 words. Each input
// word is one command: push back, push front, pop back or pop front; every command returns one
// result word with the popped value (zero unless a pop succeeded), a status (done, push rejected
// full, pop rejected empty) and the empty and full flags after the command. Rejected commands
// leave the deque unchanged. The sequencer steps through accept, execute and result load for
// every command, and a successful pop adds a read step between execute and result load for the
// registered read of the ring memory. A result waiting in the output register does not stop the
// next command from being accepted; a command only waits in its result step while the previous
// result has not been taken.
module circular_deque_ring (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [cdq_pkg::IN_W-1:0]  s_tdata,   // cmd[1:0], item_value[33:2], zero[39:34]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [cdq_pkg::OUT_W-1:0] m_tdata    // popped_value[31:0], status[33:32],
	                                             // now_empty[34], now_full[35], zero[39:36]
);

	cdq_pkg::ctl_cmd_t ctl;
	cdq_pkg::dp_stat_t stat;

	cdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (ctl)
	);

	cdq_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cmd     (ctl),
		.stat    (stat)
	);

endmodule

>>> src/cdq_checker.sv
`timescale 1ns / 1ps
// port-level checks on the deque results, bound to the top level
module cdq_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [cdq_pkg::OUT_W-1:0] m_tdata
);

	logic [cdq_pkg::STAT_W-1:0] st;
	logic                       in_seen;

	assign st      = m_tdata[33:32];
	assign in_seen = s_tvalid && s_tready;

	// a rejected word never carries a value
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st != cdq_pkg::ST_DONE) |-> m_tdata[31:0] == '0)
		else $error("rejected word carries a popped value");

	// a rejection for empty leaves the deque empty, one for full leaves it full
	a_reject_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !((st == cdq_pkg::ST_EMPTY) && !m_tdata[34])
			&& !((st == cdq_pkg::ST_FULL) && !m_tdata[35]))
		else $error("rejection disagrees with flags");

	// never empty and full at once
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[34] && m_tdata[35]))
		else $error("empty and full both set");

	// an accepted word keeps the input closed through execute and the step after it
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_seen |=> !s_tready ##1 !s_tready)
		else $error("input reopened too early");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind circular_deque_ring cdq_checker u_cdq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
